// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the nibble sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HDNS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HDNS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hdns_pkg.sv -----
// ---------------------------------------------------------------------------
// hdns_pkg
// Types, codes and tables for the HD44780 4-bit nibble sequencer.
// ---------------------------------------------------------------------------
package hdns_pkg;

    // Request item
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  byte_value;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [14:0] number;
    } req_t;

    // Transfer item
    typedef struct packed {
        logic [13:0] delay_before_us;
        logic [3:0]  nibble;
        logic        rs;
        logic [15:0] delay_after_us;
        logic        last;
    } xfer_t;

    typedef enum logic [2:0] {
        CMD_INIT     = 3'd0,
        CMD_COMMAND  = 3'd1,
        CMD_DATA     = 3'd2,
        CMD_POSITION = 3'd3,
        CMD_NUMBER   = 3'd4
    } cmd_t;

    // Config register indexes (the enable pulse timing is handled by the
    // bus driver downstream and not stored here)
    typedef enum logic [1:0] {
        CFG_PULSE_HALF   = 2'd0,
        CFG_CHAR_WAIT    = 2'd1,
        CFG_COMMAND_WAIT = 2'd2
    } cfg_index_t;

    // Display lines that set position acts on
    localparam logic [1:0] LINE_TOP    = 2'd0;
    localparam logic [1:0] LINE_BOTTOM = 2'd1;

    localparam logic [15:0] CHAR_WAIT_RESET    = 16'd80;
    localparam logic [15:0] COMMAND_WAIT_RESET = 16'd2000;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [13:0] INIT_FIRST_WAIT_US = 14'd15000;
    localparam logic [16:0] INIT_TAIL_EXTRA_US = 17'd15;
    localparam logic [7:0]  LINE0_BASE         = 8'h80;
    localparam logic [7:0]  LINE1_BASE         = 8'hC0;
    localparam logic [3:0]  ASCII_DIGIT_HI     = 4'h3;   // '0'..'9' = 0x30..0x39
    localparam logic [3:0]  LAST_STEP_LONG     = 4'd9;
    localparam logic [3:0]  LAST_STEP_BYTE     = 4'd1;

    typedef enum logic [1:0] {
        JOB_INIT   = 2'd0,
        JOB_BYTE   = 2'd1,
        JOB_NUMBER = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  byte_value;
        logic        rs;
        logic [14:0] number;
    } job_t;

    // Front -> queue write
    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic [13:0] fixed_wait;
        logic        use_cmd_wait;
        logic        use_tail;
    } init_entry_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [14:0] rem;
    } digit_t;

    function automatic logic [3:0] last_step_of(input job_kind_t kind);
        logic [3:0] res;
        unique case (kind)
            JOB_INIT:   res = LAST_STEP_LONG;
            JOB_BYTE:   res = LAST_STEP_BYTE;
            JOB_NUMBER: res = LAST_STEP_LONG;
            default:    res = LAST_STEP_BYTE;
        endcase
        return res;
    endfunction

    // Wake-up 3,3,3,2 then 0x28, 0x0C, 0x01 as nibble pairs
    function automatic init_entry_t init_entry(input logic [3:0] step);
        init_entry_t e;
        e = '0;
        unique case (step)
            4'd0:    begin e.nibble = 4'h3; e.fixed_wait = 14'd5000;  end
            4'd1:    begin e.nibble = 4'h3; e.fixed_wait = 14'd160;   end
            4'd2:    begin e.nibble = 4'h3; e.fixed_wait = 14'd160;   end
            4'd3:    begin e.nibble = 4'h2; e.fixed_wait = 14'd10000; end
            4'd4:    e.nibble = 4'h2;
            4'd5:    begin e.nibble = 4'h8; e.use_cmd_wait = 1'b1; end
            4'd6:    e.nibble = 4'h0;
            4'd7:    begin e.nibble = 4'hC; e.use_cmd_wait = 1'b1; end
            4'd8:    e.nibble = 4'h0;
            4'd9:    begin e.nibble = 4'h1; e.use_tail = 1'b1; end
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [13:0] pow10(input logic [2:0] idx);
        logic [13:0] p;
        unique case (idx)
            3'd0:    p = 14'd10000;
            3'd1:    p = 14'd1000;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

    // One decimal digit: compare against the nine multiples in parallel
    function automatic digit_t digit_step(input logic [14:0] rem, input logic [2:0] idx);
        logic [16:0] p;
        logic [16:0] r;
        logic [16:0] take;
        logic [3:0]  d;
        digit_t      res;
        p    = {3'b000, pow10(idx)};
        r    = {2'b00, rem};
        take = '0;
        d    = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= p * 17'(k)) begin
                d    = 4'(k);
                take = p * 17'(k);
            end
        end
        res.digit = d;
        res.rem   = 15'(r - take);
        return res;
    endfunction

endpackage

// ----- rtl/core/hdns_front.sv -----
// ---------------------------------------------------------------------------
// hdns_front
// Accepts requests and turns each into a job for the transfer sequencer.
// ---------------------------------------------------------------------------
module hdns_front (
    input  logic              req_valid,
    input  hdns_pkg::req_t    req,
    input  logic              queue_full,
    output hdns_pkg::job_push_t push
);
    import hdns_pkg::*;

    logic accept;
    logic has_job;
    job_t job;

    assign accept = req_valid && !queue_full;

    always_comb
    begin
        has_job        = 1'b1;
        job.kind       = JOB_BYTE;
        job.byte_value = req.byte_value;
        job.rs         = 1'b0;
        job.number     = req.number;
        unique case (req.cmd)
            CMD_INIT:    job.kind = JOB_INIT;
            CMD_COMMAND: job.rs = 1'b0;
            CMD_DATA:    job.rs = 1'b1;
            CMD_POSITION:
            begin
                // lines 2 and 3 are dropped
                if (req.line == LINE_TOP)
                    job.byte_value = LINE0_BASE + {2'b00, req.column};
                else if (req.line == LINE_BOTTOM)
                    job.byte_value = LINE1_BASE + {2'b00, req.column};
                else
                    has_job = 1'b0;
            end
            CMD_NUMBER:
            begin
                job.kind = JOB_NUMBER;
                job.rs   = 1'b1;
            end
            default:     has_job = 1'b0;
        endcase
    end

    assign push.push = accept && has_job;
    assign push.job  = job;

endmodule

// ----- rtl/core/hdns_queue.sv -----
// ---------------------------------------------------------------------------
// hdns_queue
// Short job queue between the request front and the transfer sequencer.
// ---------------------------------------------------------------------------
module hdns_queue #(
    parameter int unsigned DEPTH = hdns_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hdns_pkg::job_push_t push,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output hdns_pkg::job_t      q_job
);
    import hdns_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push.push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push.push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
            slot_reg[wr_ptr_reg] <= push.job;
    end

endmodule

// ----- rtl/core/hdns_back.sv -----
// ---------------------------------------------------------------------------
// hdns_back
// Transfer sequencer: steps through a job, one nibble transfer per cycle unless xfer_stall holds it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hdns_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       char_wait_us,
    input  logic [15:0]       command_wait_us,
    input  logic              q_valid,
    input  hdns_pkg::job_t    q_job,
    output logic              q_pop,
    output logic              xfer_valid,
    input  logic              xfer_stall,
    output hdns_pkg::xfer_t   xfer
);
    import hdns_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    job_t        job_reg, job_next;
    logic [14:0] rem_reg, rem_next;
    logic [3:0]  digit_reg, digit_next;
    logic        xfer_valid_reg, xfer_valid_next;
    xfer_t       xfer_reg, xfer_next;

    logic        issue;
    logic        at_last;
    xfer_t       cur;
    init_entry_t ie;
    digit_t      ds;
    logic [16:0] tail_sum;
    logic [15:0] tail_wait;

    assign issue   = busy_reg && (!xfer_valid_reg || !xfer_stall);
    assign at_last = (step_reg == last_step_of(job_reg.kind));
    assign q_pop   = q_valid && (!busy_reg || (issue && at_last));

    // init tail wait saturates at the 16-bit limit
    assign tail_sum  = {1'b0, command_wait_us} + INIT_TAIL_EXTRA_US;
    assign tail_wait = tail_sum[16] ? 16'hFFFF : tail_sum[15:0];

    assign ie = init_entry(step_reg);
    assign ds = digit_step(rem_reg, step_reg[3:1]);

    always_comb
    begin
        cur      = '0;
        cur.last = at_last;
        unique case (job_reg.kind)
            JOB_INIT:
            begin
                cur.nibble          = ie.nibble;
                cur.delay_before_us = (step_reg == '0) ? INIT_FIRST_WAIT_US : '0;
                if (ie.use_tail)
                    cur.delay_after_us = tail_wait;
                else if (ie.use_cmd_wait)
                    cur.delay_after_us = command_wait_us;
                else
                    cur.delay_after_us = {2'b00, ie.fixed_wait};
            end
            JOB_BYTE:
            begin
                cur.rs     = job_reg.rs;
                cur.nibble = step_reg[0] ? job_reg.byte_value[3:0] : job_reg.byte_value[7:4];
                if (step_reg[0])
                    cur.delay_after_us = job_reg.rs ? char_wait_us : command_wait_us;
            end
            JOB_NUMBER:
            begin
                cur.rs             = 1'b1;
                cur.nibble         = step_reg[0] ? digit_reg : ASCII_DIGIT_HI;
                cur.delay_after_us = step_reg[0] ? char_wait_us : '0;
            end
            default: cur = '0;
        endcase
    end

    always_comb
    begin
        busy_next       = busy_reg;
        step_next       = step_reg;
        job_next        = job_reg;
        rem_next        = rem_reg;
        digit_next      = digit_reg;
        xfer_valid_next = xfer_valid_reg;
        xfer_next       = xfer_reg;

        if (issue)
        begin
            xfer_valid_next = 1'b1;
            xfer_next       = cur;
            step_next       = step_reg + 1'b1;
            // digit is found when the high nibble issues, held in digit_reg, sent with the low nibble
            if (job_reg.kind == JOB_NUMBER && !step_reg[0])
            begin
                digit_next = ds.digit;
                rem_next   = ds.rem;
            end
            if (at_last)
                busy_next = 1'b0;
        end
        else if (!xfer_stall)
        begin
            xfer_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            busy_next = 1'b1;
            job_next  = q_job;
            step_next = '0;
            rem_next  = q_job.number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            step_reg       <= '0;
            xfer_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            xfer_valid_reg <= xfer_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
        xfer_reg  <= xfer_next;
    end

    assign xfer_valid = xfer_valid_reg;
    assign xfer       = xfer_reg;

    `HDNS_ASSERT(a_step_in_range, busy_reg |-> (step_reg <= last_step_of(job_reg.kind)), "step past end of job")
    `HDNS_ASSERT(a_digit_range, (busy_reg && job_reg.kind == JOB_NUMBER && step_reg[0]) |-> (digit_reg <= 4'd9), "decimal digit out of range")
    `HDNS_ASSERT(a_idle_after_last, (issue && at_last && !q_valid) |=> !busy_reg, "sequencer stayed busy after last transfer")
    `HDNS_ASSERT_ALWAYS(a_pop_needs_job, q_pop |-> q_valid, "pop from empty job queue")

endmodule

// ----- rtl/core/hd44780_nibble_sequencer.sv -----
// An accepted request goes via a queue slot and the job register to its transfers.
// One transfer per cycle leaves the output register unless xfer_stall holds it;
//   init and number jobs give 10 transfers, byte and position 2, dropped none.
// Requests keep coming while the job queue has room (QUEUE_DEPTH jobs).
// Reset (rst_n, async, active low) empties the queue, idles the sequencer
//   and loads the wait registers with 80 us (char) and 2000 us (command).
// ---------------------------------------------------------------------------
// hd44780_nibble_sequencer
// Turns display requests into the 4-bit transfer run of an HD44780 display.
// ---------------------------------------------------------------------------
module hd44780_nibble_sequencer #(
    parameter int unsigned QUEUE_DEPTH = hdns_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,

    // config write port
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [15:0]      cfg_wdata,

    // request channel
    input  logic             req_valid,
    output logic             req_stall,
    input  hdns_pkg::req_t   req,

    // transfer channel
    output logic             xfer_valid,
    input  logic             xfer_stall,
    output hdns_pkg::xfer_t  xfer
);
    import hdns_pkg::*;

    // Config. Index 0 (enable pulse half period) is accepted and dropped:
    // pulse timing belongs to the pin driver, no transfer field carries it.
    logic [15:0] char_wait_reg;
    logic [15:0] command_wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_wait_reg    <= CHAR_WAIT_RESET;
            command_wait_reg <= COMMAND_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_CHAR_WAIT)
                char_wait_reg <= cfg_wdata;
            if (cfg_addr == CFG_COMMAND_WAIT)
                command_wait_reg <= cfg_wdata;
        end
    end

    // Front: classify each request into a job (init, byte, number) or drop
    // it (unknown cmd, position on lines 2/3). Stall only when queue is full.
    job_push_t push;
    logic      queue_full;

    hdns_front u_front (
        .req_valid  (req_valid),
        .req        (req),
        .queue_full (queue_full),
        .push       (push)
    );

    assign req_stall = queue_full;

    // Queue decouples request intake from the slow transfer run.
    logic q_valid;
    logic q_pop;
    job_t q_job;

    hdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (queue_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_job   (q_job)
    );

    // Back: steps through a job, one transfer per cycle unless xfer_stall holds it, into an output
    // register; next job is picked up on the cycle of the last transfer.
    hdns_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_wait_us    (char_wait_reg),
        .command_wait_us (command_wait_reg),
        .q_valid         (q_valid),
        .q_job           (q_job),
        .q_pop           (q_pop),
        .xfer_valid      (xfer_valid),
        .xfer_stall      (xfer_stall),
        .xfer            (xfer)
    );

endmodule
